@@ rtl/xor_checked_frame_builder_assert.svh @@
// Assertion macros for the frame builder checker.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef XOR_CHECKED_FRAME_BUILDER_ASSERT_SVH
`define XOR_CHECKED_FRAME_BUILDER_ASSERT_SVH

// same-cycle implication
`define XCFB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define XCFB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/xcfb_pkg.sv @@
// Package for the XOR-checked frame builder: transaction types, constants,
// and the check byte function. No dependencies.
`default_nettype none
package xcfb_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 254;
  localparam int unsigned BURST_DEPTH     = 7;

  localparam logic [7:0] SYN_BYTE         = 8'd22;
  localparam logic [7:0] STX_BYTE         = 8'd2;
  localparam logic [7:0] STATION_ADDR_RST = 8'd84;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_frame;
    logic [7:0] frame_number;
    logic [9:0] frame_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_frame;
  } out_item_t;

  // bytes caused by one input transaction, byte 0 goes out first
  typedef struct packed {
    logic [BURST_DEPTH-1:0][7:0] bytes;
    logic [2:0]                  cnt;
    logic                        closes;
  } burst_t;

  function automatic logic [7:0] check_byte(input logic [7:0] x);
    logic [7:0] r;
    r = x;
    if (x == 8'h00 || x == 8'hFF) begin
      r = 8'h01;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/xor_checked_frame_builder.sv @@
// A payload byte appears at the output in the cycle after it is taken, and
// payload passes at one byte per cycle while out_ready_i is high. The byte
// that opens a frame yields six output bytes (seven if the frame is one byte
// long) and the byte that closes a frame yields two, so input stalls after a
// frame opens and at its end. The burst buffer drains one byte per cycle while
// out_ready_i is high; the next input is taken in the cycle the last pending
// byte leaves. Bytes with first_of_frame low and no frame open are dropped.
// Depends on xcfb_pkg and xcfb_framer.
`default_nettype none
module xor_checked_frame_builder #(
  parameter int unsigned MaxPayload = xcfb_pkg::MAX_PAYLOAD_DEF
) (
  input  wire                 logic clk_i,
  input  wire                 logic rst_ni,
  input  wire                 logic in_valid_i,
  output                      logic in_ready_o,
  input  wire                 xcfb_pkg::in_item_t in_data_i,
  output                      logic out_valid_o,
  input  wire                 logic out_ready_i,
  output xcfb_pkg::out_item_t       out_data_o,
  input  wire                 logic cfg_valid_i,
  output                      logic cfg_ready_o,
  input  wire                 logic [7:0] cfg_data_i
);
  import xcfb_pkg::*;

  logic [7:0]                  station_q;
  logic [BURST_DEPTH-1:0][7:0] buf_q, buf_d;
  logic [2:0]                  cnt_q, cnt_d;
  logic                        eof_q, eof_d;
  logic                        in_fire, take;
  burst_t                      burst;

  xcfb_framer #(
    .MaxPayload(MaxPayload)
  ) u_framer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (in_fire),
    .item_i        (in_data_i),
    .station_addr_i(station_q),
    .burst_o       (burst)
  );

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = (cnt_q != 3'd0);
  assign take        = out_valid_o && out_ready_i;
  assign in_ready_o  = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;

  assign out_data_o.out_byte      = buf_q[0];
  assign out_data_o.last_of_frame = eof_q && (cnt_q == 3'd1);

  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    eof_d = eof_q;
    if (take) begin
      buf_d = buf_q >> 8;
      cnt_d = cnt_q - 3'd1;
    end
    if (in_fire && (burst.cnt != 3'd0)) begin
      buf_d = burst.bytes;
      cnt_d = burst.cnt;
      eof_d = burst.closes;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_q <= STATION_ADDR_RST;
      cnt_q     <= 3'd0;
      eof_q     <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        station_q <= cfg_data_i;
      end
      cnt_q <= cnt_d;
      eof_q <= eof_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule
`default_nettype wire

@@ rtl/xcfb_framer.sv @@
// Frame state (running XOR, bytes left, open flag) and the byte burst
// that one input transaction produces. Depends on xcfb_pkg.
`default_nettype none
module xcfb_framer #(
  parameter int unsigned MaxPayload = xcfb_pkg::MAX_PAYLOAD_DEF
) (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic fire_i,
  input  wire                xcfb_pkg::in_item_t item_i,
  input  wire                logic [7:0] station_addr_i,
  output xcfb_pkg::burst_t         burst_o
);
  import xcfb_pkg::*;

  localparam logic [9:0] MaxLen = 10'(MaxPayload);

  logic [7:0] xor_q, xor_d;
  logic [7:0] left_q, left_d;
  logic       open_q, open_d;
  logic [9:0] len_c;
  logic [7:0] chk;

  always_comb begin
    len_c = item_i.frame_length;
    if (len_c > MaxLen) begin
      len_c = MaxLen;
    end else if (len_c == 10'd0) begin
      len_c = 10'd1;
    end

    if (item_i.first_of_frame) begin
      xor_d  = item_i.data_byte;
      left_d = len_c[7:0] - 8'd1;
    end else begin
      xor_d  = xor_q ^ item_i.data_byte;
      left_d = (left_q != 8'd0) ? left_q - 8'd1 : 8'd0;
    end
    chk = check_byte(xor_d);

    burst_o = '0;
    burst_o.closes = (left_d == 8'd0);
    if (item_i.first_of_frame) begin
      burst_o.bytes[0] = SYN_BYTE;
      burst_o.bytes[1] = station_addr_i;
      burst_o.bytes[2] = STX_BYTE;
      burst_o.bytes[3] = item_i.frame_number;
      burst_o.bytes[4] = len_c[7:0];
      burst_o.bytes[5] = item_i.data_byte;
      burst_o.bytes[6] = chk;
      burst_o.cnt      = burst_o.closes ? 3'd7 : 3'd6;
    end else if (open_q) begin
      burst_o.bytes[0] = item_i.data_byte;
      burst_o.bytes[1] = chk;
      burst_o.cnt      = burst_o.closes ? 3'd2 : 3'd1;
    end

    open_d = (item_i.first_of_frame || open_q) && !burst_o.closes;
    if (burst_o.closes) begin
      xor_d = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xor_q  <= 8'd0;
      left_q <= 8'd0;
      open_q <= 1'b0;
    end else if (fire_i && (item_i.first_of_frame || open_q)) begin
      xor_q  <= xor_d;
      left_q <= left_d;
      open_q <= open_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/xcfb_checker.sv @@
// Port-level assertions for the frame builder, bound to the top level.
// Depends on xcfb_pkg and xor_checked_frame_builder_assert.svh.
`default_nettype none
`include "xor_checked_frame_builder_assert.svh"
module xcfb_checker (
  input wire                 logic clk_i,
  input wire                 logic rst_ni,
  input wire                 logic in_valid_i,
  input wire                 logic in_ready_o,
  input wire                 xcfb_pkg::in_item_t in_data_i,
  input wire                 logic out_valid_o,
  input wire                 logic out_ready_i,
  input wire                 xcfb_pkg::out_item_t out_data_o
);
  import xcfb_pkg::*;

  `XCFB_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "output transaction changed while stalled")
  `XCFB_ASSERT_NOW(a_idle_ready, !out_valid_o, in_ready_o, "input not ready with output empty")
  `XCFB_ASSERT_NOW(a_ready_drain, in_ready_o && out_valid_o, out_ready_i, "input ready while output stalled")
  `XCFB_ASSERT_NEXT(a_hdr_syn, in_valid_i && in_ready_o && in_data_i.first_of_frame, out_valid_o && out_data_o.out_byte == SYN_BYTE && !out_data_o.last_of_frame, "frame did not open with SYN")

endmodule

bind xor_checked_frame_builder xcfb_checker u_xcfb_checker (.*);
`default_nettype wire
